// File: hw/rtl/gic_pkg.sv
// ----------------------------------------------------------------------------
// Greedy interval cover package
// Shared sizes, memory request structures and result field widths.
// ----------------------------------------------------------------------------
package gic_pkg;

   // Store capacity, derived index width and count width.
   localparam int MAX_SEGMENTS = 32;
   localparam int IDX_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CNT_W        = 6;

   // Field widths.
   localparam int COORD_W      = 16;
   localparam int SEG_W        = 2 * COORD_W;
   localparam int LEN_W        = 15;

   // Configuration port.
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam logic CSR_IDX_COVER_LENGTH = 1'b0;

   // Input commands.
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_SOLVE = 1'b1;

   // Header status codes.
   localparam logic STATUS_COVERED   = 1'b0;
   localparam logic STATUS_NO_COVER  = 1'b1;

   // Request to the segment store: left end in the upper half, right in the lower.
   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      logic [SEG_W-1:0] wdata;
      logic [IDX_W-1:0] raddr;
   } seg_mem_req_type;

   // Request to the store of picked segment indices.
   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      logic [IDX_W-1:0] wdata;
      logic [IDX_W-1:0] raddr;
   } pick_mem_req_type;

endpackage

// File: hw/rtl/greedy_interval_cover_unit.sv
// ----------------------------------------------------------------------------
// Greedy interval cover unit
// Loads are accepted back to back; busy stays low. A solve runs one scan round
// per chosen segment over the stored segments (one store read a cycle); the
// header is registered out after the last round, and each segment transfer
// follows a pick-index read and a segment read. Results cannot be stalled.
// Synchronous reset empties the store, clears the overflow flag and cover
// length; store contents stay undefined (no clearing pass).
// ----------------------------------------------------------------------------
module greedy_interval_cover_unit
   import gic_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_command,
   input  logic signed [COORD_W-1:0] req_seg_left,
   input  logic signed [COORD_W-1:0] req_seg_right,
   output logic                      rsp_valid,
   output logic                      rsp_is_header,
   output logic                      rsp_status,
   output logic [CNT_W-1:0]          rsp_chosen_count,
   output logic                      rsp_dropped_any,
   output logic signed [COORD_W-1:0] rsp_out_left,
   output logic signed [COORD_W-1:0] rsp_out_right,
   output logic                      rsp_last,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [CSR_DATA_W-1:0]     csr_pwdata,
   output logic [CSR_DATA_W-1:0]     csr_prdata,
   output logic                      csr_pready
);

   logic [LEN_W-1:0]  cover_length;
   seg_mem_req_type   seg_req;
   logic [SEG_W-1:0]  seg_rdata;
   pick_mem_req_type  pick_req;
   logic [IDX_W-1:0]  pick_rdata;

   // Configuration registers.
   gic_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .cover_length (cover_length)
   );

   // Segment store, left and right ends side by side.
   gic_ram #(
      .WIDTH (SEG_W),
      .DEPTH (MAX_SEGMENTS)
   ) u_seg_ram (
      .clock (clock),
      .we    (seg_req.we),
      .waddr (seg_req.waddr),
      .wdata (seg_req.wdata),
      .raddr (seg_req.raddr),
      .rdata (seg_rdata)
   );

   // Indices of the picked segments, in pick order.
   gic_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_SEGMENTS)
   ) u_pick_ram (
      .clock (clock),
      .we    (pick_req.we),
      .waddr (pick_req.waddr),
      .wdata (pick_req.wdata),
      .raddr (pick_req.raddr),
      .rdata (pick_rdata)
   );

   // Load, scan and playback sequencer.
   gic_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_seg_left     (req_seg_left),
      .req_seg_right    (req_seg_right),
      .cover_length     (cover_length),
      .seg_req          (seg_req),
      .seg_rdata        (seg_rdata),
      .pick_req         (pick_req),
      .pick_rdata       (pick_rdata),
      .rsp_valid        (rsp_valid),
      .rsp_is_header    (rsp_is_header),
      .rsp_status       (rsp_status),
      .rsp_chosen_count (rsp_chosen_count),
      .rsp_dropped_any  (rsp_dropped_any),
      .rsp_out_left     (rsp_out_left),
      .rsp_out_right    (rsp_out_right),
      .rsp_last         (rsp_last)
   );

   // An accepted solve always makes the block busy in the next cycle.
   a_solve_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_command == CMD_SOLVE)) |=> busy)
      else $error("solve transfer did not make the block busy");

   // The final transfer of a solve leaves the block free for the next item.
   a_last_frees_block: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("block still busy on the final transfer");

   // Any transfer before the final one belongs to a solve still in progress.
   a_mid_transfer_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("non-final transfer while idle");

   // A failed cover is a lone header with zero count.
   a_fail_header_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_header && (rsp_status == STATUS_NO_COVER)) |->
      (rsp_last && (rsp_chosen_count == '0)))
      else $error("failed cover header is not a lone zero-count result");

endmodule

// File: hw/rtl/gic_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined after reset.
// ----------------------------------------------------------------------------
module gic_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/gic_csr.sv
// ----------------------------------------------------------------------------
// Greedy interval cover register file
// Holds the cover length register behind a simple APB-style port.
// ----------------------------------------------------------------------------
module gic_csr
   import gic_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [LEN_W-1:0]      cover_length
);

   logic [LEN_W-1:0] cover_length_ff;
   logic [LEN_W-1:0] cover_length_in;
   logic             reg_idx;
   logic             wr_transfer;

   // The register index is the word address; byte offsets are ignored.
   assign reg_idx     = csr_paddr[2];
   assign wr_transfer = csr_psel & csr_penable & csr_pwrite;

   // A write to any index other than the cover length is ignored.
   always_comb begin
      cover_length_in = cover_length_ff;
      if (wr_transfer && (reg_idx == CSR_IDX_COVER_LENGTH)) begin
         cover_length_in = csr_pwdata[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cover_length_ff <= '0;
      end else begin
         cover_length_ff <= cover_length_in;
      end
   end

   // Read data for the addressed register.
   always_comb begin
      csr_prdata = '0;
      if (reg_idx == CSR_IDX_COVER_LENGTH) begin
         csr_prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, cover_length_ff};
      end
   end

   assign csr_pready   = 1'b1;
   assign cover_length = cover_length_ff;

endmodule

// File: hw/rtl/gic_engine.sv
// ----------------------------------------------------------------------------
// Greedy interval cover engine
// Loads segments into the store, scans it once per round to pick the segment
// reaching furthest, records the picks and plays the cover back as results.
// ----------------------------------------------------------------------------
module gic_engine
   import gic_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_command,
   input  logic signed [COORD_W-1:0]  req_seg_left,
   input  logic signed [COORD_W-1:0]  req_seg_right,
   input  logic [LEN_W-1:0]           cover_length,
   output seg_mem_req_type            seg_req,
   input  logic [SEG_W-1:0]           seg_rdata,
   output pick_mem_req_type           pick_req,
   input  logic [IDX_W-1:0]           pick_rdata,
   output logic                       rsp_valid,
   output logic                       rsp_is_header,
   output logic                       rsp_status,
   output logic [CNT_W-1:0]           rsp_chosen_count,
   output logic                       rsp_dropped_any,
   output logic signed [COORD_W-1:0]  rsp_out_left,
   output logic signed [COORD_W-1:0]  rsp_out_right,
   output logic                       rsp_last
);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SCAN     = 3'd1;
   localparam logic [2:0] ST_DRAIN    = 3'd2;
   localparam logic [2:0] ST_DECIDE   = 3'd3;
   localparam logic [2:0] ST_HEADER   = 3'd4;
   localparam logic [2:0] ST_EMIT_RDP = 3'd5;
   localparam logic [2:0] ST_EMIT_RDS = 3'd6;
   localparam logic [2:0] ST_EMIT_OUT = 3'd7;

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

   logic [2:0]                 state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       overflow_ff, overflow_in;
   logic [IDX_W-1:0]           scan_idx_ff, scan_idx_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]           rd_idx_ff, rd_idx_in;
   logic                       found_ff, found_in;
   logic [IDX_W-1:0]           best_idx_ff, best_idx_in;
   logic signed [COORD_W-1:0]  best_right_ff, best_right_in;
   logic signed [COORD_W-1:0]  mark_ff, mark_in;
   logic [CNT_W-1:0]           picks_ff, picks_in;
   logic                       failed_ff, failed_in;
   logic [CNT_W-1:0]           emit_k_ff, emit_k_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_is_header_ff, rsp_is_header_in;
   logic                       rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]           rsp_count_ff, rsp_count_in;
   logic                       rsp_dropped_ff, rsp_dropped_in;
   logic signed [COORD_W-1:0]  rsp_left_ff, rsp_left_in;
   logic signed [COORD_W-1:0]  rsp_right_ff, rsp_right_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       accept;
   logic signed [COORD_W-1:0]  rd_left;
   logic signed [COORD_W-1:0]  rd_right;
   logic signed [COORD_W-1:0]  target;
   logic                       hit;
   logic                       seg_done;

   assign accept   = start & ~busy;
   assign rd_left  = seg_rdata[SEG_W-1:COORD_W];
   assign rd_right = seg_rdata[COORD_W-1:0];
   assign target   = $signed({1'b0, cover_length});

   // A stored segment extends the mark and beats the best so far on a
   // strictly larger right end, so the earliest of equal candidates wins.
   assign hit = rd_vld_ff && (rd_left <= mark_ff) && (rd_right > mark_ff) &&
                (!found_ff || (rd_right > best_right_ff));

   assign seg_done = ((emit_k_ff + CNT_W'(1)) == picks_ff);

   // Sequencer and datapath next state.
   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      overflow_in      = overflow_ff;
      scan_idx_in      = scan_idx_ff;
      rd_vld_in        = 1'b0;
      rd_idx_in        = scan_idx_ff;
      found_in         = found_ff;
      best_idx_in      = best_idx_ff;
      best_right_in    = best_right_ff;
      mark_in          = mark_ff;
      picks_in         = picks_ff;
      failed_in        = failed_ff;
      emit_k_in        = emit_k_ff;

      rsp_valid_in     = 1'b0;
      rsp_is_header_in = rsp_is_header_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_count_in     = rsp_count_ff;
      rsp_dropped_in   = rsp_dropped_ff;
      rsp_left_in      = rsp_left_ff;
      rsp_right_in     = rsp_right_ff;
      rsp_last_in      = rsp_last_ff;

      seg_req          = '0;
      seg_req.waddr    = count_ff[IDX_W-1:0];
      seg_req.wdata    = {req_seg_left, req_seg_right};
      seg_req.raddr    = scan_idx_ff;
      pick_req         = '0;
      pick_req.waddr   = picks_ff[IDX_W-1:0];
      pick_req.wdata   = best_idx_ff;
      pick_req.raddr   = emit_k_ff[IDX_W-1:0];

      // Fold the segment read last cycle into the running best.
      if (hit) begin
         found_in      = 1'b1;
         best_idx_in   = rd_idx_ff;
         best_right_in = rd_right;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_command == CMD_LOAD)) begin
               if (count_ff < CNT_MAX) begin
                  seg_req.we = 1'b1;
                  count_in   = count_ff + CNT_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
            end else if (accept) begin
               mark_in     = '0;
               picks_in    = '0;
               failed_in   = 1'b0;
               found_in    = 1'b0;
               scan_idx_in = '0;
               if (cover_length == '0) begin
                  state_in = ST_HEADER;
               end else if (count_ff == '0) begin
                  state_in = ST_DECIDE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         // Issue one store read per cycle, in load order.
         ST_SCAN: begin
            rd_vld_in = 1'b1;
            if (({1'b0, scan_idx_ff} + CNT_W'(1)) == count_ff) begin
               state_in = ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end

         // The last read of the round is compared in this cycle.
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end

         // Record the pick and advance the mark, or give up.
         ST_DECIDE: begin
            if (!found_ff || (picks_ff == CNT_MAX)) begin
               failed_in = 1'b1;
               state_in  = ST_HEADER;
            end else begin
               pick_req.we = 1'b1;
               picks_in    = picks_ff + CNT_W'(1);
               mark_in     = best_right_ff;
               if (best_right_ff >= target) begin
                  state_in = ST_HEADER;
               end else begin
                  found_in    = 1'b0;
                  scan_idx_in = '0;
                  state_in    = ST_SCAN;
               end
            end
         end

         // Header transfer; the store is emptied here.
         ST_HEADER: begin
            rsp_valid_in     = 1'b1;
            rsp_is_header_in = 1'b1;
            rsp_status_in    = failed_ff ? STATUS_NO_COVER : STATUS_COVERED;
            rsp_count_in     = failed_ff ? '0 : picks_ff;
            rsp_dropped_in   = overflow_ff;
            rsp_left_in      = '0;
            rsp_right_in     = '0;
            rsp_last_in      = failed_ff || (picks_ff == '0);
            count_in         = '0;
            overflow_in      = 1'b0;
            emit_k_in        = '0;
            if (failed_ff || (picks_ff == '0)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_EMIT_RDP;
            end
         end

         // Fetch the index of the next pick.
         ST_EMIT_RDP: begin
            state_in = ST_EMIT_RDS;
         end

         // Fetch the picked segment itself.
         ST_EMIT_RDS: begin
            seg_req.raddr = pick_rdata;
            state_in      = ST_EMIT_OUT;
         end

         // Segment transfer.
         ST_EMIT_OUT: begin
            rsp_valid_in     = 1'b1;
            rsp_is_header_in = 1'b0;
            rsp_status_in    = STATUS_COVERED;
            rsp_count_in     = '0;
            rsp_dropped_in   = 1'b0;
            rsp_left_in      = rd_left;
            rsp_right_in     = rd_right;
            rsp_last_in      = seg_done;
            emit_k_in        = emit_k_ff + CNT_W'(1);
            if (seg_done) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_EMIT_RDP;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         picks_ff     <= '0;
         failed_ff    <= 1'b0;
         emit_k_ff    <= '0;
         scan_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rd_vld_ff    <= rd_vld_in;
         found_ff     <= found_in;
         picks_ff     <= picks_in;
         failed_ff    <= failed_in;
         emit_k_ff    <= emit_k_in;
         scan_idx_ff  <= scan_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_idx_ff        <= rd_idx_in;
      best_idx_ff      <= best_idx_in;
      best_right_ff    <= best_right_in;
      mark_ff          <= mark_in;
      rsp_is_header_ff <= rsp_is_header_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_count_ff     <= rsp_count_in;
      rsp_dropped_ff   <= rsp_dropped_in;
      rsp_left_ff      <= rsp_left_in;
      rsp_right_ff     <= rsp_right_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_header    = rsp_is_header_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_chosen_count = rsp_count_ff;
   assign rsp_dropped_any  = rsp_dropped_ff;
   assign rsp_out_left     = rsp_left_ff;
   assign rsp_out_right    = rsp_right_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// File: test/gic_cover_checker.sv
// ----------------------------------------------------------------------------
// Greedy interval cover checker
// Watches the load/solve channel, the result channel and the register port,
// keeps its own copy of the segment store and cover length, predicts the
// header and chosen segments of every solve and compares each result transfer
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module gic_cover_checker
   import gic_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic                      req_command,
   input  logic signed [COORD_W-1:0] req_seg_left,
   input  logic signed [COORD_W-1:0] req_seg_right,
   input  logic                      rsp_valid,
   input  logic                      rsp_is_header,
   input  logic                      rsp_status,
   input  logic [CNT_W-1:0]          rsp_chosen_count,
   input  logic                      rsp_dropped_any,
   input  logic signed [COORD_W-1:0] rsp_out_left,
   input  logic signed [COORD_W-1:0] rsp_out_right,
   input  logic                      rsp_last,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [CSR_DATA_W-1:0]     csr_pwdata,
   input  logic [CSR_DATA_W-1:0]     csr_prdata,
   input  logic                      csr_pready,
   output int                        fail_count,
   output int                        outstanding,
   output int                        checked_count,
   output int                        uncovered_count,
   output int                        overflow_count
);

   localparam int MAX_REPORTS = 10;

   // One result transfer as it appears on the rsp_ ports.
   typedef struct packed {
      logic                      is_header;
      logic                      status;
      logic [CNT_W-1:0]          count;
      logic                      dropped;
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] right;
      logic                      last;
   } cover_result_type;

   // Shadow copy of the block state.
   logic signed [COORD_W-1:0] left_mem  [MAX_SEGMENTS];
   logic signed [COORD_W-1:0] right_mem [MAX_SEGMENTS];
   int                        seg_count;
   logic                      dropped_flag;
   logic [LEN_W-1:0]          cover_len;

   cover_result_type pending_covers[$];
   int               mismatches;
   int               checked;
   int               uncovered;
   int               overflowed;

   function automatic string show(cover_result_type r);
      return $sformatf("hdr=%0b st=%0b cnt=%0d drop=%0b left=%0d right=%0d last=%0b",
                       r.is_header, r.status, r.count, r.dropped, r.left, r.right,
                       r.last);
   endfunction

   task automatic flag(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%t: %s", $realtime, msg);
      end
   endtask

   // Greedy cover of [0, cover_len] over the stored segments; queues the header
   // and the chosen segments, then empties the store.
   function automatic void solve_cover();
      int               mark;
      int               target;
      int               best;
      int               best_right;
      bit               found;
      bit               failed;
      int               picked[$];
      cover_result_type res;

      mark   = 0;
      target = int'(cover_len);
      failed = 1'b0;
      while (mark < target && !failed) begin
         found      = 1'b0;
         best       = 0;
         best_right = 0;
         // Earliest segment holding the mark that reaches furthest.
         for (int i = 0; i < seg_count; i++) begin
            if (int'(left_mem[i]) <= mark && int'(right_mem[i]) > mark &&
                (!found || int'(right_mem[i]) > best_right)) begin
               found      = 1'b1;
               best       = i;
               best_right = int'(right_mem[i]);
            end
         end
         if (!found || picked.size() >= MAX_SEGMENTS) begin
            failed = 1'b1;
         end else begin
            picked = {picked, best};
            mark = best_right;
         end
      end

      res.is_header = 1'b1;
      res.status    = failed ? STATUS_NO_COVER : STATUS_COVERED;
      res.count     = failed ? '0 : CNT_W'(picked.size());
      res.dropped   = dropped_flag;
      res.left      = '0;
      res.right     = '0;
      res.last      = failed || picked.size() == 0;
      pending_covers = {pending_covers, res};
      if (failed) begin
         uncovered++;
      end
      if (dropped_flag) begin
         overflowed++;
      end

      if (!failed) begin
         foreach (picked[k]) begin
            res.is_header = 1'b0;
            res.status    = STATUS_COVERED;
            res.count     = '0;
            res.dropped   = 1'b0;
            res.left      = left_mem[picked[k]];
            res.right     = right_mem[picked[k]];
            res.last      = (k == picked.size() - 1);
            pending_covers = {pending_covers, res};
         end
      end

      seg_count    = 0;
      dropped_flag = 1'b0;
   endfunction

   always @(posedge clock) begin
      cover_result_type got;
      cover_result_type want;
      string            bad;
      int               reg_idx;

      if (reset) begin
         seg_count    = 0;
         dropped_flag = 1'b0;
         cover_len    = '0;
         pending_covers.delete();
      end else begin
         // Register port: writes update the shadow length, reads are checked.
         if (csr_psel && csr_penable && csr_pready) begin
            reg_idx = int'(csr_paddr >> 2);
            if (csr_pwrite) begin
               if (reg_idx == int'(CSR_IDX_COVER_LENGTH)) begin
                  cover_len = csr_pwdata[LEN_W-1:0];
               end
            end else if (reg_idx == int'(CSR_IDX_COVER_LENGTH) &&
                         csr_prdata !== CSR_DATA_W'(cover_len)) begin
               flag($sformatf("cover_length read: expected %0d, got %0h",
                              cover_len, csr_prdata));
            end
         end

         // Result channel.
         if (rsp_valid !== 1'b0) begin
            got.is_header = rsp_is_header;
            got.status    = rsp_status;
            got.count     = rsp_chosen_count;
            got.dropped   = rsp_dropped_any;
            got.left      = rsp_out_left;
            got.right     = rsp_out_right;
            got.last      = rsp_last;
            if (rsp_valid !== 1'b1) begin
               flag("result strobe is unknown");
            end else if (pending_covers.size() == 0) begin
               flag($sformatf("unexpected result transfer: %s", show(got)));
            end else begin
               want = pending_covers.pop_front();
               bad  = "";
               if (got.is_header !== want.is_header) bad = {bad, " is_header"};
               if (got.status !== want.status)       bad = {bad, " status"};
               if (got.count !== want.count)         bad = {bad, " chosen_count"};
               if (got.dropped !== want.dropped)     bad = {bad, " dropped_any"};
               if (got.left !== want.left)           bad = {bad, " out_left"};
               if (got.right !== want.right)         bad = {bad, " out_right"};
               if (got.last !== want.last)           bad = {bad, " last"};
               if (bad != "") begin
                  flag($sformatf("result %0d wrong in%s: expected %s, got %s",
                                 checked, bad, show(want), show(got)));
               end
               checked++;
            end
         end

         // Input channel: loads fill the store, a solve queues its cover.
         if (start === 1'b1 && busy === 1'b0) begin
            if (req_command == CMD_LOAD) begin
               if (seg_count < MAX_SEGMENTS) begin
                  left_mem[seg_count]  = req_seg_left;
                  right_mem[seg_count] = req_seg_right;
                  seg_count++;
               end else begin
                  dropped_flag = 1'b1;
               end
            end else begin
               solve_cover();
            end
         end
      end

      fail_count      <= mismatches;
      outstanding     <= pending_covers.size();
      checked_count   <= checked;
      uncovered_count <= uncovered;
      overflow_count  <= overflowed;
   end

endmodule

// File: test/tb_greedy_interval_cover_unit.sv
// ----------------------------------------------------------------------------
// Greedy interval cover unit testbench
// Drives directed and random load/solve sequences under several cover lengths,
// with random gaps between transfers, and leaves prediction and comparison to
// the cover checker. A watchdog ends the run if the block stops making progress.
// ----------------------------------------------------------------------------
module tb_greedy_interval_cover_unit;
   import gic_pkg::*;

   localparam int ITEM_TARGET    = 230;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_CYCLES   = 20;
   localparam int MAX_OVERFLOWS  = 2;
   localparam int UNUSED_REG_IDX = 1;
   localparam logic [CSR_ADDR_W-1:0] COVER_LENGTH_ADDR =
      CSR_ADDR_W'(CSR_IDX_COVER_LENGTH) << 2;
   localparam logic [CSR_ADDR_W-1:0] UNUSED_REG_ADDR = CSR_ADDR_W'(UNUSED_REG_IDX) << 2;
   localparam int COORD_MIN = -32768;
   localparam int COORD_MAX = 32767;

   typedef enum int {SET_CHAIN, SET_BROKEN, SET_NOISE, SET_OVERFLOW} set_kind_type;

   typedef struct {
      int l;
      int r;
   } span_type;

   logic                      clock;
   logic                      reset         = 1'b1;
   logic                      start         = 1'b0;
   logic                      busy;
   logic                      req_command   = CMD_LOAD;
   logic signed [COORD_W-1:0] req_seg_left  = '0;
   logic signed [COORD_W-1:0] req_seg_right = '0;
   logic                      rsp_valid;
   logic                      rsp_is_header;
   logic                      rsp_status;
   logic [CNT_W-1:0]          rsp_chosen_count;
   logic                      rsp_dropped_any;
   logic signed [COORD_W-1:0] rsp_out_left;
   logic signed [COORD_W-1:0] rsp_out_right;
   logic                      rsp_last;
   logic                      csr_psel      = 1'b0;
   logic                      csr_penable   = 1'b0;
   logic                      csr_pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0]     csr_paddr     = '0;
   logic [CSR_DATA_W-1:0]     csr_pwdata    = '0;
   logic [CSR_DATA_W-1:0]     csr_prdata;
   logic                      csr_pready;

   int fail_count;
   int outstanding;
   int checked_count;
   int uncovered_count;
   int overflow_count;

   int load_count;
   int solve_count;
   int setting_count;
   int overflow_sets;
   int quiet_cycles;

   greedy_interval_cover_unit uut (.*);

   gic_cover_checker cover_chk (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: counts cycles with no transfer on any port.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_greedy_interval_cover_unit failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int rand_coord();
      return int'($urandom_range(0, 65535)) + COORD_MIN;
   endfunction

   // Mostly back to back, often a short gap, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // One transfer on the input channel; returns at the edge that accepts it.
   task automatic send_item(input logic cmd, input int l, input int r, input bit quiet);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_command   <= cmd;
      req_seg_left  <= COORD_W'(l);
      req_seg_right <= COORD_W'(r);
      do @(posedge clock); while (busy !== 1'b0);
      if (cmd == CMD_LOAD) load_count++;
      else solve_count++;
   endtask

   // Hold the sender off until every predicted result has arrived.
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0 || busy !== 1'b0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // New cover length with random upper data bits, read back, and sometimes a
   // write to the unused register beside it.
   task automatic set_cover_length(input int len);
      setting_count++;
      if ($urandom_range(0, 1)) begin
         csr_access(1'b1, UNUSED_REG_ADDR, $urandom);
      end
      csr_access(1'b1, COVER_LENGTH_ADDR, {17'($urandom), LEN_W'(len)});
      csr_access(1'b0, COVER_LENGTH_ADDR, '0);
   endtask

   // One random set of loads followed by a solve.
   task automatic run_cover_set(input set_kind_type kind, input int len);
      span_type segs[$];
      span_type s;
      span_type tmp;
      int       mark;
      int       span;
      int       d;
      int       extra;
      bit       quiet;

      // A chain of up to 20 overlapping segments from zero towards the end of the range.
      mark = 0;
      if (kind != SET_NOISE) begin
         while (mark < len && segs.size() < 20) begin
            span = len / int'($urandom_range(1, 8)) + 1;
            d    = $urandom_range(1, span);
            s.r  = (mark + d > COORD_MAX) ? COORD_MAX : mark + d;
            d    = $urandom_range(0, span);
            s.l  = (mark - d < COORD_MIN) ? COORD_MIN : mark - d;
            segs = {segs, s};
            mark = s.r;
         end
      end
      if (kind == SET_BROKEN && segs.size() > 0) begin
         segs.delete($urandom_range(0, segs.size() - 1));
      end

      // Decoys: half anywhere in the coordinate space, half near the range.
      if (kind == SET_OVERFLOW) extra = int'($urandom_range(33, 38)) - segs.size();
      else extra = $urandom_range(0, (kind == SET_NOISE) ? 10 : 6);
      repeat (extra) begin
         if ($urandom_range(0, 1)) begin
            s.l = rand_coord();
            s.r = rand_coord();
         end else begin
            s.l = int'($urandom_range(0, len)) - int'($urandom_range(0, 64));
            s.r = s.l + int'($urandom_range(0, 128)) - 8;
            if (s.r > COORD_MAX) s.r = COORD_MAX;
         end
         segs = {segs, s};
      end

      for (int j = segs.size() - 1; j > 0; j--) begin
         d       = $urandom_range(0, j);
         tmp     = segs[j];
         segs[j] = segs[d];
         segs[d] = tmp;
      end

      quiet = ($urandom_range(0, 3) == 0);
      foreach (segs[k]) send_item(CMD_LOAD, segs[k].l, segs[k].r, quiet);
      send_item(CMD_SOLVE, rand_coord(), rand_coord(), quiet);
   endtask

   initial begin
      int           len;
      int           phase;
      int           set_no;
      int           roll;
      set_kind_type kind;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Zero length: a sum-to-zero segment is stored, nothing is chosen.
      wait_idle();
      set_cover_length(0);
      send_item(CMD_LOAD, 5, -5, 1'b1);
      send_item(CMD_SOLVE, 0, 0, 1'b1);
      send_item(CMD_SOLVE, -1, 1, 1'b0);

      // Full range: ties go to the earliest segment; an empty store cannot cover.
      wait_idle();
      set_cover_length(COORD_MAX);
      send_item(CMD_LOAD, 0, 100, 1'b1);
      send_item(CMD_LOAD, COORD_MIN, COORD_MAX, 1'b1);
      send_item(CMD_LOAD, COORD_MIN, COORD_MAX, 1'b1);
      send_item(CMD_SOLVE, COORD_MAX, COORD_MIN, 1'b1);
      send_item(CMD_SOLVE, 0, 0, 1'b0);

      // Short range with overlaps, a reversed extreme segment, and then a
      // store whose only segment does not hold the mark.
      wait_idle();
      set_cover_length(10);
      send_item(CMD_LOAD, 0, 4, 1'b0);
      send_item(CMD_LOAD, -3, 3, 1'b0);
      send_item(CMD_LOAD, 2, 7, 1'b0);
      send_item(CMD_LOAD, 4, 10, 1'b0);
      send_item(CMD_LOAD, 7, 12, 1'b0);
      send_item(CMD_LOAD, COORD_MAX, COORD_MIN, 1'b0);
      send_item(CMD_LOAD, 1, 5, 1'b0);
      send_item(CMD_SOLVE, 0, 0, 1'b0);
      send_item(CMD_LOAD, 1, 5, 1'b0);
      send_item(CMD_SOLVE, 0, 0, 1'b0);

      // Random sets, a few per cover length, lengths cycling through extremes.
      phase  = 0;
      set_no = 0;
      while (load_count + solve_count < ITEM_TARGET) begin
         case (phase % 6)
            0:       len = 1;
            1:       len = COORD_MAX;
            2:       len = $urandom_range(0, COORD_MAX);
            3:       len = 0;
            4:       len = $urandom_range(2, 400);
            default: len = $urandom_range(20000, COORD_MAX);
         endcase
         wait_idle();
         set_cover_length(len);
         repeat ($urandom_range(2, 5)) begin
            if (load_count + solve_count < ITEM_TARGET) begin
               roll = $urandom_range(0, 11);
               if (set_no == 0 || (roll == 2 && overflow_sets < MAX_OVERFLOWS)) begin
                  kind = SET_OVERFLOW;
                  overflow_sets++;
               end else if (roll == 0) begin
                  kind = SET_NOISE;
               end else if (roll == 1) begin
                  kind = SET_BROKEN;
               end else begin
                  kind = SET_CHAIN;
               end
               run_cover_set(kind, len);
               set_no++;
            end
         end
         phase++;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Summary: %0d segment loads and %0d solves under %0d cover lengths,",
               load_count, solve_count, setting_count);
      $display("Summary: %0d result transfers checked, %0d uncoverable, %0d with drops.",
               checked_count, uncovered_count, overflow_count);
      if (fail_count == 0) begin
         $display("tb_greedy_interval_cover_unit passed");
      end else begin
         $display("tb_greedy_interval_cover_unit failed");
      end
      $finish;
   end

endmodule
